>>> src/tfb_pkg.sv
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants for the bounding-box to tile-index lookup.
// ----------------------------------------------------------------------------
package tfb_pkg;

    // Level table geometry.
    localparam int MAX_LEVELS = 32;
    localparam int LVL_W      = $clog2(MAX_LEVELS);

    // Field widths.
    localparam int COORD_W = 48;
    localparam int RES_W   = 47;
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 6;
    localparam int TILE_W  = 32;

    // Shared divider: dividend magnitude and divisor widths.
    localparam int DVD_W     = COORD_W + 1;
    localparam int DVS_W     = RES_W + DIM_W;
    localparam int DIV_STEPS = DVD_W;

    // Shared multiplier widths.
    localparam int MUL_A_W = DVD_W;
    localparam int PROD_W  = MUL_A_W + DIM_W;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd2;

    // Item kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_WRONG_SZ  = 2'd1;
    localparam logic [1:0] STAT_NO_LEVEL  = 2'd2;
    localparam logic [1:0] STAT_MISALIGN  = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [16:0] {
        ST_IDLE       = 17'b0_0000_0000_0000_0001,
        ST_PREP_X     = 17'b0_0000_0000_0000_0010,
        ST_DIV_X      = 17'b0_0000_0000_0000_0100,
        ST_PREP_Y     = 17'b0_0000_0000_0000_1000,
        ST_DIV_Y      = 17'b0_0000_0000_0001_0000,
        ST_RES        = 17'b0_0000_0000_0010_0000,
        ST_SCAN_RD    = 17'b0_0000_0000_0100_0000,
        ST_SCAN_DIFF  = 17'b0_0000_0000_1000_0000,
        ST_SCAN_MUL   = 17'b0_0000_0001_0000_0000,
        ST_SCAN_CMP   = 17'b0_0000_0010_0000_0000,
        ST_SPAN_X     = 17'b0_0000_0100_0000_0000,
        ST_SNAP_X_DIV = 17'b0_0000_1000_0000_0000,
        ST_SNAP_X_FIN = 17'b0_0001_0000_0000_0000,
        ST_SPAN_Y     = 17'b0_0010_0000_0000_0000,
        ST_SNAP_Y_DIV = 17'b0_0100_0000_0000_0000,
        ST_SNAP_Y_FIN = 17'b0_1000_0000_0000_0000,
        ST_FINISH     = 17'b1_0000_0000_0000_0000
    } state_t;

endpackage

>>> src/tile_index_from_bbox_unit.sv
// ----------------------------------------------------------------------------
// tile_index_from_bbox_unit
// Matches a bounding box to a zoom level and returns its tile column and row.
// ----------------------------------------------------------------------------
// Kind 0 items write one level table entry. A kind 1 item with a tile size
// that differs from the configured one goes straight to its result with a
// wrong-size status. A full lookup divides for the box resolution, scans the
// levels, and divides again for the column and the row. The work is done by
// one shared restoring divider that retires one quotient bit per cycle and by
// one shared multiplier used for the level test and the tile spans. The input
// is stalled while a lookup is at work, so the block takes no new item before
// the last one is done; a finished result sits in an output register until
// it is taken.
module tile_index_from_bbox_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [tfb_pkg::DIM_W-1:0]     cfg_data,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [4:0]                    level_index,
    input  logic [tfb_pkg::RES_W-1:0]     level_resolution,
    input  logic signed [tfb_pkg::COORD_W-1:0] level_origin_x,
    input  logic signed [tfb_pkg::COORD_W-1:0] level_origin_y,
    input  logic signed [tfb_pkg::COORD_W-1:0] min_x,
    input  logic signed [tfb_pkg::COORD_W-1:0] min_y,
    input  logic signed [tfb_pkg::COORD_W-1:0] max_x,
    input  logic signed [tfb_pkg::COORD_W-1:0] max_y,
    input  logic [tfb_pkg::DIM_W-1:0]     req_width,
    input  logic [tfb_pkg::DIM_W-1:0]     req_height,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [4:0]                    level,
    output logic signed [tfb_pkg::TILE_W-1:0] tile_x,
    output logic signed [tfb_pkg::TILE_W-1:0] tile_y
);
    import tfb_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0] tile_width_reg, tile_height_reg;
    logic [CNT_W-1:0] level_count_reg;

    // Level table.
    logic [RES_W-1:0]   res_mem [MAX_LEVELS];
    logic [COORD_W-1:0] ox_mem  [MAX_LEVELS];
    logic [COORD_W-1:0] oy_mem  [MAX_LEVELS];
    logic [RES_W-1:0]   rd_res_reg;
    logic [COORD_W-1:0] rd_ox_reg, rd_oy_reg;

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    logic [COORD_W-1:0] mnx_reg, mny_reg, mxx_reg, mxy_reg;
    logic [COORD_W-1:0] mnx_next, mny_next, mxx_next, mxy_next;
    logic [DVD_W-1:0]   qx_reg, qx_next;
    logic [DVD_W-1:0]   res_reg, res_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [DVD_W-1:0]   ad_reg, ad_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DVS_W-1:0]   div_rem_reg, div_rem_next;
    logic [DVD_W-1:0]   div_quo_reg, div_quo_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic               neg_reg, neg_next;
    logic               x_ok_reg, x_ok_next;
    logic [TILE_W-1:0]  px_reg, px_next;
    logic [TILE_W-1:0]  py_reg, py_next;
    logic [1:0]         stat_reg, stat_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [4:0]         level_reg, level_next;
    logic [TILE_W-1:0]  tile_x_reg, tile_x_next;
    logic [TILE_W-1:0]  tile_y_reg, tile_y_next;

    // Handshakes.
    logic in_fire, out_load;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Effective tile dimensions and the level count clamped to the table size.
    logic [DIM_W-1:0] tw_eff, th_eff, mdim;
    logic [CNT_W-1:0] count;
    assign tw_eff = (tile_width_reg == '0) ? DIM_W'(1) : tile_width_reg;
    assign th_eff = (tile_height_reg == '0) ? DIM_W'(1) : tile_height_reg;
    assign mdim   = (tw_eff > th_eff) ? tw_eff : th_eff;
    assign count  = (level_count_reg > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS)
                                                            : level_count_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= DIM_W'(256);
            tile_height_reg <= DIM_W'(256);
            level_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TILE_WIDTH)
                tile_width_reg <= cfg_data;
            if (cfg_index == CFG_TILE_HEIGHT)
                tile_height_reg <= cfg_data;
            if (cfg_index == CFG_LEVEL_COUNT)
                level_count_reg <= cfg_data[CNT_W-1:0];
        end
    end

    // Level table: written by kind 0 items, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (in_fire && kind == KIND_WRITE && 32'(level_index) < 32'(MAX_LEVELS))
        begin
            res_mem[level_index[LVL_W-1:0]] <= level_resolution;
            ox_mem[level_index[LVL_W-1:0]]  <= level_origin_x;
            oy_mem[level_index[LVL_W-1:0]]  <= level_origin_y;
        end
        rd_res_reg <= res_mem[idx_reg[LVL_W-1:0]];
        rd_ox_reg  <= ox_mem[idx_reg[LVL_W-1:0]];
        rd_oy_reg  <= oy_mem[idx_reg[LVL_W-1:0]];
    end

    // Shared multiplier operands.
    logic [MUL_A_W-1:0] mul_a;
    logic [DIM_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    always_comb
    begin
        mul_a = MUL_A_W'(1);
        mul_b = tw_eff;
        unique case (state_reg)
            ST_PREP_Y:   mul_b = th_eff;
            ST_SCAN_MUL:
            begin
                mul_a = ad_reg;
                mul_b = mdim;
            end
            ST_SPAN_X:   mul_a = MUL_A_W'(rd_res_reg);
            ST_SPAN_Y:
            begin
                mul_a = MUL_A_W'(rd_res_reg);
                mul_b = th_eff;
            end
            default:     mul_a = MUL_A_W'(1);
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Shared divider step: one quotient bit per cycle, divisor in prod_reg.
    logic [DVS_W-1:0] divisor;
    logic [DVS_W:0]   trial;
    logic             trial_ge;
    logic [DVS_W-1:0] step_rem;
    logic [DVD_W-1:0] step_quo;
    logic             div_last;
    assign divisor  = prod_reg[DVS_W-1:0];
    assign trial    = {div_rem_reg, div_quo_reg[DVD_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign step_rem = trial_ge ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
    assign step_quo = {div_quo_reg[DVD_W-2:0], trial_ge};
    assign div_last = (div_cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Box extents, positive part only.
    logic [COORD_W:0] dx, dy;
    logic [DVD_W-1:0] dx_mag, dy_mag;
    assign dx     = {mxx_reg[COORD_W-1], mxx_reg} - {mnx_reg[COORD_W-1], mnx_reg};
    assign dy     = {mxy_reg[COORD_W-1], mxy_reg} - {mny_reg[COORD_W-1], mny_reg};
    assign dx_mag = dx[COORD_W] ? '0 : dx;
    assign dy_mag = dy[COORD_W] ? '0 : dy;

    // Offsets of the lower corner from the level origin.
    logic [COORD_W:0] nx, ny;
    assign nx = {mnx_reg[COORD_W-1], mnx_reg} - {rd_ox_reg[COORD_W-1], rd_ox_reg};
    assign ny = {mny_reg[COORD_W-1], mny_reg} - {rd_oy_reg[COORD_W-1], rd_oy_reg};

    // Distance between a table resolution and the box resolution.
    logic [DVD_W:0] rdiff;
    assign rdiff = {3'b0, rd_res_reg} - {1'b0, res_reg};

    // Rounding, saturation and alignment check on a finished division.
    logic             snap_up;
    logic [DVD_W:0]   snap_q;
    logic [DVS_W-1:0] snap_err;
    logic             snap_sat;
    logic [TILE_W-1:0] snap_pat;
    logic             snap_ok;
    logic [DVD_W:0]   snap_negq;
    always_comb
    begin
        snap_up   = {div_rem_reg, 1'b0} >= {1'b0, divisor};
        snap_q    = {1'b0, div_quo_reg} + (DVD_W + 1)'(snap_up);
        snap_err  = snap_up ? (divisor - div_rem_reg) : div_rem_reg;
        snap_negq = '0 - snap_q;
        snap_sat  = 1'b0;
        snap_pat  = snap_q[TILE_W-1:0];
        if (!neg_reg && snap_q > (DVD_W + 1)'(32'h7FFF_FFFF))
        begin
            snap_sat = 1'b1;
            snap_pat = 32'h7FFF_FFFF;
        end
        else if (neg_reg && snap_q > (DVD_W + 1)'(32'h8000_0000))
        begin
            snap_sat = 1'b1;
            snap_pat = 32'h8000_0000;
        end
        else if (neg_reg)
        begin
            snap_pat = snap_negq[TILE_W-1:0];
        end
        snap_ok = !snap_sat && (snap_err <= DVS_W'(rd_res_reg));
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mnx_next       = mnx_reg;
        mny_next       = mny_reg;
        mxx_next       = mxx_reg;
        mxy_next       = mxy_reg;
        qx_next        = qx_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        ad_next        = ad_reg;
        prod_next      = prod_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        neg_next       = neg_reg;
        x_ok_next      = x_ok_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        stat_next      = stat_reg;
        status_next    = status_reg;
        level_next     = level_reg;
        tile_x_next    = tile_x_reg;
        tile_y_next    = tile_y_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && kind == KIND_LOOKUP)
                begin
                    mnx_next = min_x;
                    mny_next = min_y;
                    mxx_next = max_x;
                    mxy_next = max_y;
                    px_next  = '0;
                    idx_next = '0;
                    if (req_width != tile_width_reg || req_height != tile_height_reg)
                    begin
                        stat_next  = STAT_WRONG_SZ;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PREP_X;
                    end
                end
            end
            ST_PREP_X, ST_PREP_Y:
            begin
                // Divisor is the tile dimension; dividend the box extent.
                prod_next    = mul_p;
                div_rem_next = '0;
                div_cnt_next = '0;
                div_quo_next = (state_reg == ST_PREP_X) ? dx_mag : dy_mag;
                if (state_reg == ST_PREP_Y)
                    qx_next = div_quo_reg;
                state_next   = (state_reg == ST_PREP_X) ? ST_DIV_X : ST_DIV_Y;
            end
            ST_DIV_X, ST_DIV_Y, ST_SNAP_X_DIV, ST_SNAP_Y_DIV:
            begin
                div_rem_next = step_rem;
                div_quo_next = step_quo;
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    unique case (state_reg)
                        ST_DIV_X:      state_next = ST_PREP_Y;
                        ST_DIV_Y:      state_next = ST_RES;
                        ST_SNAP_X_DIV: state_next = ST_SNAP_X_FIN;
                        default:       state_next = ST_SNAP_Y_FIN;
                    endcase
                end
            end
            ST_RES:
            begin
                // Box resolution is the larger per-axis quotient.
                res_next = (qx_reg > div_quo_reg) ? qx_reg : div_quo_reg;
                if (qx_reg == '0 && div_quo_reg == '0 || count == '0)
                begin
                    stat_next  = STAT_NO_LEVEL;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_DIFF;
            end
            ST_SCAN_DIFF:
            begin
                ad_next    = rdiff[DVD_W] ? DVD_W'('0 - rdiff) : rdiff[DVD_W-1:0];
                state_next = ST_SCAN_MUL;
            end
            ST_SCAN_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                // Level test: |r - res| * max(tile_w, tile_h) < res.
                if (prod_reg < PROD_W'(res_reg))
                begin
                    state_next = ST_SPAN_X;
                end
                else if (idx_reg + CNT_W'(1) >= count)
                begin
                    stat_next  = STAT_NO_LEVEL;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SPAN_X, ST_SPAN_Y:
            begin
                // Tile span becomes the divisor; offset magnitude the dividend.
                prod_next    = mul_p;
                div_rem_next = '0;
                div_cnt_next = '0;
                if (state_reg == ST_SPAN_X)
                begin
                    neg_next     = nx[COORD_W];
                    div_quo_next = nx[COORD_W] ? DVD_W'('0 - nx) : nx;
                    state_next   = ST_SNAP_X_DIV;
                end
                else
                begin
                    neg_next     = ny[COORD_W];
                    div_quo_next = ny[COORD_W] ? DVD_W'('0 - ny) : ny;
                    state_next   = ST_SNAP_Y_DIV;
                end
            end
            ST_SNAP_X_FIN:
            begin
                px_next    = snap_pat;
                x_ok_next  = snap_ok;
                state_next = ST_SPAN_Y;
            end
            ST_SNAP_Y_FIN:
            begin
                py_next    = snap_pat;
                stat_next  = (x_ok_reg && snap_ok) ? STAT_OK : STAT_MISALIGN;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // The output register is loaded only once the last result is gone.
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = stat_reg;
                    if (stat_reg == STAT_WRONG_SZ || stat_reg == STAT_NO_LEVEL)
                    begin
                        level_next  = '0;
                        tile_x_next = '0;
                        tile_y_next = '0;
                    end
                    else
                    begin
                        level_next  = idx_reg[4:0];
                        tile_x_next = px_reg;
                        tile_y_next = py_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            idx_reg       <= idx_next;
        end
    end

    // Datapath and result payload.
    always_ff @(posedge clk)
    begin
        mnx_reg     <= mnx_next;
        mny_reg     <= mny_next;
        mxx_reg     <= mxx_next;
        mxy_reg     <= mxy_next;
        qx_reg      <= qx_next;
        res_reg     <= res_next;
        ad_reg      <= ad_next;
        prod_reg    <= prod_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        neg_reg     <= neg_next;
        x_ok_reg    <= x_ok_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        stat_reg    <= stat_next;
        status_reg  <= status_next;
        level_reg   <= level_next;
        tile_x_reg  <= tile_x_next;
        tile_y_reg  <= tile_y_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_valid_reg ? status_reg : STAT_OK;
    assign level     = level_reg;
    assign tile_x    = tile_x_reg;
    assign tile_y    = tile_y_reg;

`ifndef ASSERT_OFF
    // The divider remainder stays below a nonzero divisor while dividing.
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_X || state_reg == ST_DIV_Y ||
         state_reg == ST_SNAP_X_DIV || state_reg == ST_SNAP_Y_DIV)
        |-> (divisor != '0 && div_rem_reg < divisor))
        else $error("divider remainder out of range");

    // A scan only runs with a positive box resolution and an index in range.
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_DIFF) |-> (res_reg != '0 && idx_reg < count))
        else $error("level scan out of range");

    // A matched level lies below the scanned count when its span is formed.
    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAN_X) |-> (idx_reg < count && $past(state_reg) == ST_SCAN_CMP))
        else $error("matched level out of range");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounding-box to tile-index lookup. A short
// table of hand-picked transfers and register writes runs first. Random
// phases under several grid tile sizes and level counts follow. Every
// result is compared with the bench's own tile predictor or a fixed
// expected answer, and both sides of the data path idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import tfb_pkg::*;

    // Kinds of rows in the stimulus table.
    localparam int ROW_ITEM = 0;
    localparam int ROW_CFG  = 1;

    // Cycles that cover a full lookup over every level, with margin.
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [1:0]         status;
        logic [4:0]         level;
        logic [TILE_W-1:0]  tile_x;
        logic [TILE_W-1:0]  tile_y;
    } tile_result_t;

    typedef struct {
        int                  op;
        logic [1:0]          cfg_reg;
        logic [DIM_W-1:0]    cfg_val;
        logic                kind;
        logic [4:0]          lvl_idx;
        logic [RES_W-1:0]    lvl_res;
        logic [COORD_W-1:0]  lvl_ox;
        logic [COORD_W-1:0]  lvl_oy;
        logic [COORD_W-1:0]  mnx;
        logic [COORD_W-1:0]  mny;
        logic [COORD_W-1:0]  mxx;
        logic [COORD_W-1:0]  mxy;
        logic [DIM_W-1:0]    rw;
        logic [DIM_W-1:0]    rh;
        bit                  typed;
        tile_result_t        want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index;
    logic [DIM_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        kind;
    logic [4:0]                  level_index;
    logic [RES_W-1:0]            level_resolution;
    logic signed [COORD_W-1:0]   level_origin_x;
    logic signed [COORD_W-1:0]   level_origin_y;
    logic signed [COORD_W-1:0]   min_x;
    logic signed [COORD_W-1:0]   min_y;
    logic signed [COORD_W-1:0]   max_x;
    logic signed [COORD_W-1:0]   max_y;
    logic [DIM_W-1:0]            req_width;
    logic [DIM_W-1:0]            req_height;
    logic                        out_valid;
    logic                        out_stall;
    logic [1:0]                  status;
    logic [4:0]                  level;
    logic signed [TILE_W-1:0]    tile_x;
    logic signed [TILE_W-1:0]    tile_y;

    // Predictor state: grid configuration and level table copy.
    longint unsigned  grid_res [MAX_LEVELS];
    longint           grid_ox [MAX_LEVELS];
    longint           grid_oy [MAX_LEVELS];
    logic [DIM_W-1:0] grid_tw;
    logic [DIM_W-1:0] grid_th;
    logic [CNT_W-1:0] grid_levels;

    tile_result_t     pending_tiles [$];
    stim_row_t        directed_rows [$];
    int               fail_count;
    int               lookup_count;
    int               table_write_count;
    int               status_seen [4];
    logic             hold_off;

    tile_index_from_bbox_unit uut (.*);

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Rounds n / s half away from zero and reports the distance to the grid.
    task automatic snap_to_grid(input longint n, input longint unsigned s,
                                output logic [31:0] pat, output longint unsigned err,
                                output bit in_range);
        bit neg;
        longint unsigned mag, q, r;
        neg = n < 0;
        mag = neg ? (64'd0 - longint'(n)) : n;
        q = mag / s;
        r = mag % s;
        if (2 * r >= s)
        begin
            q = q + 1;
            err = s - r;
        end
        else
            err = r;
        in_range = 1'b1;
        if (!neg && q > 64'h7FFF_FFFF)
        begin
            pat = 32'h7FFF_FFFF;
            in_range = 1'b0;
        end
        else if (neg && q > 64'h8000_0000)
        begin
            pat = 32'h8000_0000;
            in_range = 1'b0;
        end
        else
            pat = 32'(neg ? (64'd0 - q) : q);
    endtask

    // Tile predictor for one lookup under the current grid state.
    task automatic predict_tile(input stim_row_t row, output tile_result_t p);
        longint tw, th, mnx, mny, mxx, mxy, rx, ry, res, d;
        longint unsigned mdim, ad, r, spx, spy, ex, ey;
        int cnt, lvl;
        bit found, okx, oky;
        logic [31:0] px, py;
        p = '{STAT_OK, 5'd0, 32'd0, 32'd0};
        if (row.rw != grid_tw || row.rh != grid_th)
        begin
            p.status = STAT_WRONG_SZ;
            return;
        end
        tw = (grid_tw == 0) ? 1 : grid_tw;
        th = (grid_th == 0) ? 1 : grid_th;
        mnx = longint'(signed'(row.mnx));
        mny = longint'(signed'(row.mny));
        mxx = longint'(signed'(row.mxx));
        mxy = longint'(signed'(row.mxy));
        rx = (mxx - mnx) / tw;
        ry = (mxy - mny) / th;
        res = (rx > ry) ? rx : ry;
        mdim = (tw > th) ? tw : th;
        cnt = (grid_levels < MAX_LEVELS) ? grid_levels : MAX_LEVELS;
        found = 1'b0;
        lvl = 0;
        if (res > 0)
        begin
            for (int i = 0; i < cnt && !found; i++)
            begin
                d = longint'(grid_res[i]) - res;
                ad = (d < 0) ? (64'd0 - d) : d;
                if (ad * mdim < longint'(res))
                begin
                    found = 1'b1;
                    lvl = i;
                end
            end
        end
        if (!found)
        begin
            p.status = STAT_NO_LEVEL;
            return;
        end
        r = grid_res[lvl];
        spx = r * tw;
        spy = r * th;
        px = 0; py = 0; ex = 0; ey = 0; okx = 0; oky = 0;
        if (spx != 0)
            snap_to_grid(mnx - grid_ox[lvl], spx, px, ex, okx);
        if (spy != 0)
            snap_to_grid(mny - grid_oy[lvl], spy, py, ey, oky);
        p.status = (okx && oky && ex <= r && ey <= r) ? STAT_OK : STAT_MISALIGN;
        p.level = 5'(lvl);
        p.tile_x = px;
        p.tile_y = py;
    endtask

    function automatic stim_row_t row_cfg(logic [1:0] idx, logic [DIM_W-1:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.op = ROW_CFG;
        r.cfg_reg = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic stim_row_t row_level(logic [4:0] idx, logic [RES_W-1:0] res,
                                            logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
        stim_row_t r;
        r = '{default: '0};
        r.op = ROW_ITEM;
        r.kind = KIND_WRITE;
        r.lvl_idx = idx;
        r.lvl_res = res;
        r.lvl_ox = ox;
        r.lvl_oy = oy;
        r.mnx = {COORD_W{1'b1}};
        r.rw = DIM_W'($urandom);
        return r;
    endfunction

    function automatic stim_row_t row_box(longint mnx, longint mny, longint mxx, longint mxy,
                                          logic [DIM_W-1:0] rw, logic [DIM_W-1:0] rh);
        stim_row_t r;
        r = '{default: '0};
        r.op = ROW_ITEM;
        r.kind = KIND_LOOKUP;
        r.lvl_idx = 5'($urandom);
        r.lvl_res = RES_W'({$urandom, $urandom});
        r.mnx = mnx[COORD_W-1:0];
        r.mny = mny[COORD_W-1:0];
        r.mxx = mxx[COORD_W-1:0];
        r.mxy = mxy[COORD_W-1:0];
        r.rw = rw;
        r.rh = rh;
        return r;
    endfunction

    function automatic stim_row_t row_typed(stim_row_t r, logic [1:0] st);
        r.typed = 1'b1;
        r.want = '{st, 5'd0, 32'd0, 32'd0};
        return r;
    endfunction

    // Waits out any work in flight, then writes one register.
    task automatic write_register(logic [1:0] idx, logic [DIM_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_tiles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TILE_WIDTH:  grid_tw = val;
            CFG_TILE_HEIGHT: grid_th = val;
            CFG_LEVEL_COUNT: grid_levels = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one transfer and books its effect once it is taken.
    task automatic offer_item(stim_row_t row);
        tile_result_t p;
        in_valid <= 1'b1;
        kind <= row.kind;
        level_index <= row.lvl_idx;
        level_resolution <= row.lvl_res;
        level_origin_x <= row.lvl_ox;
        level_origin_y <= row.lvl_oy;
        min_x <= row.mnx;
        min_y <= row.mny;
        max_x <= row.mxx;
        max_y <= row.mxy;
        req_width <= row.rw;
        req_height <= row.rh;
        do
            @(posedge clk);
        while (in_stall);
        if (row.kind == KIND_WRITE)
        begin
            table_write_count++;
            grid_res[row.lvl_idx] = row.lvl_res;
            grid_ox[row.lvl_idx] = longint'(signed'(row.lvl_ox));
            grid_oy[row.lvl_idx] = longint'(signed'(row.lvl_oy));
        end
        else
        begin
            lookup_count++;
            if (row.typed)
                p = row.want;
            else
                predict_tile(row, p);
            pending_tiles.push_back(p);
        end
    endtask

    // Random level table entry: mostly modest resolutions, a few extremes.
    function automatic stim_row_t random_level();
        logic [RES_W-1:0] res;
        logic [COORD_W-1:0] ox, oy;
        case ($urandom_range(0, 9))
            0: res = RES_W'({$urandom, $urandom});
            1: res = {RES_W{1'b1}};
            default: res = $urandom_range(1, 1 << 20);
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            ox = COORD_W'({$urandom, $urandom});
            oy = COORD_W'({$urandom, $urandom});
        end
        else
        begin
            ox = COORD_W'(longint'($urandom) * 256 - (longint'(1) << 39));
            oy = COORD_W'(longint'($urandom) * 256 - (longint'(1) << 39));
        end
        return row_level(5'($urandom), res, ox, oy);
    endfunction

    // Box sized to one tile of a loaded level, placed near its grid.
    function automatic stim_row_t random_grid_box();
        int cnt, lvl;
        longint r, tw, th, spx, spy, mnx, mny;
        cnt = (grid_levels < MAX_LEVELS) ? grid_levels : MAX_LEVELS;
        lvl = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
        r = grid_res[lvl];
        tw = (grid_tw == 0) ? 1 : grid_tw;
        th = (grid_th == 0) ? 1 : grid_th;
        spx = r * tw;
        spy = r * th;
        mnx = grid_ox[lvl] + (longint'($urandom_range(0, 2000)) - 1000) * spx;
        mny = grid_oy[lvl] + (longint'($urandom_range(0, 2000)) - 1000) * spy;
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                mnx = mnx + longint'({$urandom, $urandom} % (2 * r + 1)) - r;
                mny = mny + longint'({$urandom, $urandom} % (2 * r + 1)) - r;
            end
            2:
            begin
                mnx = mnx + spx / 2;
                mny = mny - spy / 2;
            end
            default:
            begin
                mnx = mnx + longint'({$urandom, $urandom} % (4 * r + 1)) - 2 * r;
                mny = mny + r + 1;
            end
        endcase
        return row_box(mnx, mny, mnx + spx + $urandom_range(0, 3), mny + spy,
                       grid_tw, grid_th);
    endfunction

    // Unshaped lookup: random box and, at times, a random tile size.
    function automatic stim_row_t random_noise_box();
        stim_row_t r;
        r = row_box({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, grid_tw, grid_th);
        if ($urandom_range(0, 1))
            r.rw = DIM_W'($urandom_range(1, 4096));
        if ($urandom_range(0, 1))
            r.rh = DIM_W'($urandom_range(1, 4096));
        return r;
    endfunction

    // Result checker and receiver stall pattern.
    int stall_left = 0;
    int stall_mode = 0;
    always @(posedge clk)
    begin
        tile_result_t w;
        if (out_valid && !out_stall)
        begin
            if (pending_tiles.size() == 0)
            begin
                $error("result transfer with no expected tile pending");
                fail_count++;
            end
            else
            begin
                w = pending_tiles.pop_front();
                status_seen[status]++;
                if (status !== w.status)
                begin
                    $error("status: expected %0d, actual %0d", w.status, status);
                    fail_count++;
                end
                if (level !== w.level)
                begin
                    $error("level: expected %0d, actual %0d", w.level, level);
                    fail_count++;
                end
                if (tile_x !== w.tile_x)
                begin
                    $error("tile_x: expected %0d, actual %0d",
                           $signed(w.tile_x), tile_x);
                    fail_count++;
                end
                if (tile_y !== w.tile_y)
                begin
                    $error("tile_y: expected %0d, actual %0d",
                           $signed(w.tile_y), tile_y);
                    fail_count++;
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 600);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= hold_off;
            1: out_stall <= hold_off | ($urandom_range(0, 1) == 1);
            default: out_stall <= hold_off | ($urandom_range(0, 7) != 0);
        endcase
    end

    // Long receiver hold-off while the sender keeps offering lookups.
    initial
    begin
        hold_off = 1'b0;
        wait (lookup_count >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Run limit.
    initial
    begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [DIM_W-1:0] phase_cfg [8][3];
        int burst_left, pick;
        stim_row_t row;
        longint span1;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_WRITE;
        level_index = '0;
        level_resolution = '0;
        level_origin_x = '0;
        level_origin_y = '0;
        min_x = '0;
        min_y = '0;
        max_x = '0;
        max_y = '0;
        req_width = '0;
        req_height = '0;
        fail_count = 0;
        lookup_count = 0;
        table_write_count = 0;
        status_seen = '{0, 0, 0, 0};
        grid_tw = 256;
        grid_th = 256;
        grid_levels = 0;
        foreach (grid_res[i])
        begin
            grid_res[i] = 0;
            grid_ox[i] = 0;
            grid_oy[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table. Reset state first: no levels, so answers are fixed.
        directed_rows.push_back(row_typed(row_box(0, 0, 65536 * 256, 65536 * 256, 256, 256),
                                          STAT_NO_LEVEL));
        directed_rows.push_back(row_typed(row_box(0, 0, 1, 1, 255, 256), STAT_WRONG_SZ));
        directed_rows.push_back(row_typed(row_box(0, 0, 1, 1, 256, 4096), STAT_WRONG_SZ));
        directed_rows.push_back(row_typed(row_box(0, 0, 1, 1, 1, 1), STAT_WRONG_SZ));
        directed_rows.push_back(row_typed(row_box(-(longint'(1) << 47), -(longint'(1) << 47),
                                                  (longint'(1) << 47) - 1,
                                                  (longint'(1) << 47) - 1, 256, 256),
                                          STAT_NO_LEVEL));
        // Fill the whole level table: level i < 29 is (i+1)<<16 map units/pixel.
        for (int i = 0; i < 29; i++)
            directed_rows.push_back(row_level(5'(i), RES_W'((i + 1) << 16), 0, 0));
        directed_rows.push_back(row_level(29, 0, 0, 0));
        directed_rows.push_back(row_level(30, 1, 0, 0));
        directed_rows.push_back(row_level(31, {RES_W{1'b1}}, {1'b1, {(COORD_W-1){1'b0}}},
                                          {1'b0, {(COORD_W-1){1'b1}}}));
        directed_rows.push_back(row_cfg(CFG_LEVEL_COUNT, 32));
        // Aligned box on level 3, then an exact half tile, an inverted and an
        // empty box, and a negative column.
        span1 = longint'(4 << 16) * 256;
        directed_rows.push_back(row_box(5 * span1, 7 * span1, 6 * span1, 8 * span1, 256, 256));
        directed_rows.push_back(row_box(5 * span1 / 2, 0, 7 * span1 / 2, span1, 256, 256));
        directed_rows.push_back(row_box(span1, span1, 0, 0, 256, 256));
        directed_rows.push_back(row_box(span1, span1, span1, span1, 256, 256));
        directed_rows.push_back(row_box(-5 * span1, -span1, -4 * span1, 0, 256, 256));
        // Tile index overflow in both directions on a one-pixel grid.
        directed_rows.push_back(row_cfg(CFG_TILE_WIDTH, 1));
        directed_rows.push_back(row_cfg(CFG_TILE_HEIGHT, 1));
        directed_rows.push_back(row_box((longint'(1) << 47) - 2, 0,
                                        (longint'(1) << 47) - 1, 1, 1, 1));
        directed_rows.push_back(row_box(-(longint'(1) << 47), -(longint'(1) << 47),
                                        -(longint'(1) << 47) + 1,
                                        -(longint'(1) << 47) + 1, 1, 1));
        // Level count beyond the table depth.
        directed_rows.push_back(row_cfg(CFG_LEVEL_COUNT, 63));
        directed_rows.push_back(row_box(3, 9, 4, 10, 1, 1));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
                write_register(directed_rows[i].cfg_reg, directed_rows[i].cfg_val);
            else
                offer_item(directed_rows[i]);
        end
        in_valid <= 1'b0;

        // Random phases, each under its own grid setting.
        phase_cfg[0] = '{256, 256, 32};
        phase_cfg[1] = '{4096, 4096, 63};
        phase_cfg[2] = '{1, 1, 32};
        phase_cfg[3] = '{17, 4096, 8};
        phase_cfg[4] = '{4096, 1, 1};
        for (int k = 5; k < 8; k++)
            phase_cfg[k] = '{DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)),
                             DIM_W'($urandom_range(0, 63))};
        foreach (phase_cfg[k])
        begin
            write_register(CFG_TILE_WIDTH, phase_cfg[k][0]);
            write_register(CFG_TILE_HEIGHT, phase_cfg[k][1]);
            write_register(CFG_LEVEL_COUNT, phase_cfg[k][2]);
            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < 100; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    row = random_grid_box();
                else if (pick < 8)
                    row = random_level();
                else
                    row = random_noise_box();
                offer_item(row);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    if ($urandom_range(0, 3) != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 40)) @(posedge clk);
                    end
                end
            end
            in_valid <= 1'b0;
        end

        // Drain.
        while (pending_tiles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lookups and %0d level writes over 8 grid settings.",
                 lookup_count, table_write_count);
        $display("Results by status: ok %0d, wrong size %0d, no level %0d, misaligned %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
